// ===== hdl/rrt_pkg.sv =====
// Shared types, constants and character helpers for the reversed-radix
// text-to-binary converter. No dependencies.
`default_nettype none

package rrt_pkg;

  // Width of the running total and weight.
  localparam int unsigned VALUE_BITS = 32;
  // Fixed port widths.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CH_W = 8;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 5;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = DIGIT_W'(16);

  localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CH_W-1:0] CH_TAB = 8'h09;
  localparam logic [CH_W-1:0] CH_CR = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE = 8'h39;
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
  localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;

  typedef enum logic [1:0] {
    KIND_BAD = 2'd0,
    KIND_OK  = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic [CH_W-1:0]     bad_char;
    logic [VALUE_W-1:0]  value;
    logic                overflow;
  } res_t;

  function automatic logic [DIGIT_W-1:0] decode_digit(input logic [CH_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NOT_A_DIGIT;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
      d = DIGIT_W'(c - CH_LOWER_A) + DIGIT_W'(10);
    end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
      d = DIGIT_W'(c - CH_UPPER_A) + DIGIT_W'(10);
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  // Out-of-range radix values are pinned to the nearest legal base.
  function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rrt_core.sv =====
// Number state and per-character update for the converter: decodes one
// character, forms the report word and advances total and weight. Uses rrt_pkg.
`default_nettype none

module rrt_core
  import rrt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire logic [CH_W-1:0]    ch_i,
  input  wire logic [RADIX_W-1:0] radix_i,
  output res_t                    res_o
);

  logic                  started_q, started_d;
  logic [VALUE_BITS-1:0] weight_q, weight_d;
  logic                  wh_q, wh_d;
  logic [VALUE_BITS-1:0] total_q, total_d;
  logic                  err_q, err_d;
  logic                  ovf_q, ovf_d;

  logic [RADIX_W-1:0]    base;
  logic [DIGIT_W-1:0]    digit;
  logic                  skip;
  logic                  newline;
  logic                  bad;
  logic [VALUE_BITS+3:0] prod_full;
  logic [VALUE_BITS+4:0] wprod_full;
  logic [VALUE_BITS:0]   sum;

  always_comb begin
    base       = clamp_base(radix_i);
    digit      = decode_digit(ch_i);
    skip       = !started_q && is_space(ch_i);
    newline    = (ch_i == CH_NEWLINE);
    bad        = !newline && (digit >= DIGIT_W'(base));
    prod_full  = (VALUE_BITS+4)'(weight_q) * (VALUE_BITS+4)'(digit[3:0]);
    wprod_full = (VALUE_BITS+5)'(weight_q) * (VALUE_BITS+5)'(base);
    sum        = {1'b0, total_q} + {1'b0, prod_full[VALUE_BITS-1:0]};
  end

  always_comb begin
    res_o.valid    = !skip && (newline || bad);
    res_o.kind     = KIND_BAD;
    res_o.bad_char = '0;
    res_o.value    = '0;
    res_o.overflow = 1'b0;
    if (newline) begin
      res_o.kind     = err_q ? KIND_ERR : KIND_OK;
      res_o.value    = err_q ? '0 : VALUE_W'(total_q);
      res_o.overflow = ovf_q;
    end else begin
      res_o.bad_char = ch_i;
    end
  end

  always_comb begin
    started_d = started_q;
    weight_d  = weight_q;
    wh_d      = wh_q;
    total_d   = total_q;
    err_d     = err_q;
    ovf_d     = ovf_q;
    if (fire_i && !skip) begin
      started_d = 1'b1;
      if (newline) begin
        started_d = 1'b0;
        weight_d  = VALUE_BITS'(1);
        wh_d      = 1'b0;
        total_d   = '0;
        err_d     = 1'b0;
        ovf_d     = 1'b0;
      end else if (bad) begin
        err_d = 1'b1;
      end else begin
        if (digit != '0) begin
          total_d = sum[VALUE_BITS-1:0];
          if (wh_q || (|prod_full[VALUE_BITS+3:VALUE_BITS]) || sum[VALUE_BITS]) begin
            ovf_d = 1'b1;
          end
        end
        weight_d = wprod_full[VALUE_BITS-1:0];
        if (|wprod_full[VALUE_BITS+4:VALUE_BITS]) begin
          wh_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      weight_q  <= VALUE_BITS'(1);
      wh_q      <= 1'b0;
      total_q   <= '0;
      err_q     <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      started_q <= started_d;
      weight_q  <= weight_d;
      wh_q      <= wh_d;
      total_q   <= total_d;
      err_q     <= err_d;
      ovf_q     <= ovf_d;
    end
  end

`ifndef NO_ASSERTIONS
  // While skipping leading whitespace the number state must be clean.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> (weight_q == VALUE_BITS'(1) && total_q == '0 && !err_q && !ovf_q && !wh_q))
    else $error("number state not clean before start");

  // A consumed newline of a started number ends it.
  a_newline_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && started_q && newline) |=> !started_q)
    else $error("newline did not end the number");

  // A bad-digit report leaves the number marked erroneous.
  a_bad_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.valid && res_o.kind == KIND_BAD) |=> err_q)
    else $error("bad digit did not set the error flag");

  // The weight-high flag is sticky until the number ends.
  a_wh_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wh_q && !(fire_i && newline)) |=> wh_q)
    else $error("weight-high flag dropped inside a number");
`endif

endmodule

`default_nettype wire

// ===== hdl/reversed_radix_text_to_binary.sv =====
// Top level of the reversed-radix text-to-binary converter: input register,
// radix register and result register around rrt_core. Uses rrt_pkg.
`default_nettype none

// Usage
// The input channel (valid_i, stall_o, ch_i) carries one ASCII character per
// word, least significant digit first; a newline ends the number. A word is
// taken at a rising edge with valid_i high and stall_o low.
// The output channel (valid_o, stall_i and the four result ports) carries one
// word per bad digit and one per finished number; whitespace before a number
// and accepted digits give no output word.
// The radix is written with radix_we_i / radix_i while the block is idle;
// values below 2 act as 2 and values above 16 act as 16.
// A character sits in the input register, where the decode, the
// digit-times-weight and weight-times-base products and the total update
// are done; its result word is then registered in the result register,
// which drives valid_o.
// Throughput is one character per cycle while stall_o is low; the number
// state is updated from the input register as each character leaves it.
// When the receiver stalls, the result register holds its word; characters that
// give no result still drain, and the input register stalls only when it holds
// a character that needs the occupied result register.
// Reset clears the number state, empties both registers and sets the radix to 16.

module reversed_radix_text_to_binary
  import rrt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               radix_we_i,
  input  wire logic [RADIX_W-1:0] radix_i,
  input  wire logic               valid_i,
  output      logic               stall_o,
  input  wire logic [CH_W-1:0]    ch_i,
  output      logic               valid_o,
  input  wire logic               stall_i,
  output      logic [1:0]         report_kind_o,
  output      logic [CH_W-1:0]    bad_char_o,
  output      logic [VALUE_W-1:0] value_o,
  output      logic               overflow_o
);

  logic [RADIX_W-1:0] radix_q;
  logic               in_valid_q, in_valid_d;
  logic [CH_W-1:0]    ch_q;
  logic               out_valid_q, out_valid_d;
  res_t               res_q;
  res_t               res;
  logic               out_free;
  logic               core_fire;
  logic               in_accept;

  rrt_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (core_fire),
    .ch_i    (ch_q),
    .radix_i (radix_q),
    .res_o   (res)
  );

  // A character leaves the input register when it gives no word or when the
  // result register is free in this cycle.
  always_comb begin
    out_free    = !out_valid_q || !stall_i;
    core_fire   = in_valid_q && (!res.valid || out_free);
    stall_o     = in_valid_q && !core_fire;
    in_accept   = valid_i && !stall_o;
    in_valid_d  = in_accept || (in_valid_q && !core_fire);
    out_valid_d = (core_fire && res.valid) || (out_valid_q && stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (radix_we_i) begin
        radix_q <= radix_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q <= ch_i;
    end
    if (core_fire && res.valid) begin
      res_q <= res;
    end
  end

  assign valid_o       = out_valid_q;
  assign report_kind_o = res_q.kind;
  assign bad_char_o    = res_q.bad_char;
  assign value_o       = res_q.value;
  assign overflow_o    = res_q.overflow;

endmodule

`default_nettype wire
